// File: sv/bamd_pkg.sv
package bamd_pkg;

  // default operand width
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // operation codes
  typedef logic [1:0] op_t;
  localparam op_t OP_ADD = 2'd0;
  localparam op_t OP_SUB = 2'd1;
  localparam op_t OP_MUL = 2'd2;
  localparam op_t OP_DIV = 2'd3;

endpackage

// File: sv/bamd_if.sv
// request channel: operation and two operands
interface bamd_in_if #(
  parameter int unsigned W = bamd_pkg::DATA_WIDTH_DEF
);
  import bamd_pkg::*;

  logic                valid;
  logic                ready;
  op_t                 operation;
  logic signed [W-1:0] operand_a;
  logic signed [W-1:0] operand_b;

  modport source (output valid, output operation, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input operation, input operand_a, input operand_b,
                output ready);
endinterface

// result channel: one word per request
interface bamd_out_if #(
  parameter int unsigned W = bamd_pkg::DATA_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] result_value;
  logic                divide_by_zero;

  modport source (output valid, output result_value, output divide_by_zero, input ready);
  modport sink (input valid, input result_value, input divide_by_zero, output ready);
endinterface

// File: sv/bitwise_add_mul_div_unit.sv
// signed integer unit with one shared adder/subtractor under a small sequencer.
// each request word carries an operation (add, subtract, multiply, divide) and two
// two's complement operands of DATA_WIDTH bits; exactly one result word comes back.
// add and subtract wrap. multiply is an unsigned shift-and-add over all multiplier
// bits and keeps the low DATA_WIDTH bits, which equal the low bits of the signed
// product. divide is restoring shift-subtract on the operand magnitudes; the
// quotient truncates toward zero, takes the xor of the operand signs, and the most
// negative value over minus one wraps to itself. a zero divisor gives 0 with
// divide_by_zero set. before the result is offered, add/subtract take the sum, multiply
// works over every multiplier bit, divide does two operand negations, one bit per cycle
// and one quotient negation, and divide by zero goes straight to the result. every
// step goes through the single adder, so one request is in flight at a time and
// in_chan.ready is high only while the sequencer is idle. a finished result sits in
// an output register, so a new request may be taken while it waits to be read.
module bitwise_add_mul_div_unit #(
  parameter int unsigned DATA_WIDTH = bamd_pkg::DATA_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  bamd_in_if.sink    in_chan,
  bamd_out_if.source out_chan
);
  import bamd_pkg::*;

  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_NEGA = 3'd3;
  localparam logic [2:0] S_NEGB = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_NEGQ = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]            state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [DATA_WIDTH-1:0] a_r, a_nxt;      // multiplicand, or dividend / quotient
  logic [DATA_WIDTH-1:0] b_r, b_nxt;      // multiplier, or divisor
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;  // product, remainder, or final result
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  neg_r, neg_nxt;  // quotient takes a minus sign
  logic                  dz_r, dz_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_value_r, out_value_nxt;
  logic                  out_dz_r, out_dz_nxt;

  // shared adder ports
  logic [DATA_WIDTH-1:0] add_x, add_y, add_sum;
  logic                  add_sub, add_carry;

  // remainder shifted left with the next dividend bit
  logic [DATA_WIDTH-1:0] rem_shift;

  logic in_fire, out_fire, out_free;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_fire       = out_valid_r && out_chan.ready;
  assign out_free       = !out_valid_r || out_chan.ready;

  assign out_chan.valid          = out_valid_r;
  assign out_chan.result_value   = out_value_r;
  assign out_chan.divide_by_zero = out_dz_r;

  assign rem_shift = {acc_r[DATA_WIDTH-2:0], a_r[DATA_WIDTH-1]};

  bamd_addsub #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_addsub (
    .x     (add_x),
    .y     (add_y),
    .sub   (add_sub),
    .sum   (add_sum),
    .carry (add_carry)
  );

  // adder operand selection per step
  always_comb begin
    add_x   = acc_r;
    add_y   = b_r;
    add_sub = 1'b0;
    case (state_r)
      S_ADD: begin
        add_x   = a_r;
        add_y   = b_r;
        add_sub = (op_r == OP_SUB);
      end
      S_MUL: begin
        add_x = acc_r;
        add_y = a_r;
      end
      S_NEGA: begin
        add_x   = '0;
        add_y   = a_r;
        add_sub = 1'b1;
      end
      S_NEGB: begin
        add_x   = '0;
        add_y   = b_r;
        add_sub = 1'b1;
      end
      S_DIV: begin
        add_x   = rem_shift;
        add_y   = b_r;
        add_sub = 1'b1;
      end
      S_NEGQ: begin
        add_x   = '0;
        add_y   = a_r;
        add_sub = 1'b1;
      end
      default: begin
        add_x   = acc_r;
        add_y   = b_r;
        add_sub = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    dz_nxt        = dz_r;
    out_valid_nxt = out_fire ? 1'b0 : out_valid_r;
    out_value_nxt = out_value_r;
    out_dz_nxt    = out_dz_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt  = in_chan.operation;
          a_nxt   = in_chan.operand_a;
          b_nxt   = in_chan.operand_b;
          acc_nxt = '0;
          cnt_nxt = '0;
          neg_nxt = in_chan.operand_a[DATA_WIDTH-1] ^ in_chan.operand_b[DATA_WIDTH-1];
          dz_nxt  = 1'b0;
          case (in_chan.operation)
            OP_ADD, OP_SUB: state_nxt = S_ADD;
            OP_MUL:         state_nxt = S_MUL;
            default: begin
              if (in_chan.operand_b == '0) begin
                // zero divisor: result 0 with the flag
                dz_nxt    = 1'b1;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_NEGA;
              end
            end
          endcase
        end
      end
      S_ADD: begin
        acc_nxt   = add_sum;
        state_nxt = S_DONE;
      end
      S_MUL: begin
        // one multiplier bit per cycle, multiplicand moves left
        if (b_r[0]) begin
          acc_nxt = add_sum;
        end
        a_nxt   = {a_r[DATA_WIDTH-2:0], 1'b0};
        b_nxt   = {1'b0, b_r[DATA_WIDTH-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_NEGA: begin
        if (a_r[DATA_WIDTH-1]) begin
          a_nxt = add_sum;
        end
        state_nxt = S_NEGB;
      end
      S_NEGB: begin
        if (b_r[DATA_WIDTH-1]) begin
          b_nxt = add_sum;
        end
        acc_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // restoring step: keep the difference only when there is no borrow,
        // quotient bits enter at the bottom of a_r as dividend bits leave the top
        acc_nxt = add_carry ? add_sum : rem_shift;
        a_nxt   = {a_r[DATA_WIDTH-2:0], add_carry};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_NEGQ;
        end
      end
      S_NEGQ: begin
        acc_nxt   = neg_r ? add_sum : a_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold here while the output register still has an unread word
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = acc_r;
          out_dz_nxt    = dz_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    acc_r       <= acc_nxt;
    cnt_r       <= cnt_nxt;
    neg_r       <= neg_nxt;
    dz_r        <= dz_nxt;
    out_value_r <= out_value_nxt;
    out_dz_r    <= out_dz_nxt;
  end

endmodule

// File: sv/bamd_addsub.sv
module bamd_addsub #(
  parameter int unsigned DATA_WIDTH = bamd_pkg::DATA_WIDTH_DEF
) (
  input  logic [DATA_WIDTH-1:0] x,
  input  logic [DATA_WIDTH-1:0] y,
  input  logic                  sub,
  output logic [DATA_WIDTH-1:0] sum,
  output logic                  carry
);
  logic [DATA_WIDTH:0] full;

  // x - y as x + ~y + 1; carry out set means no borrow (x >= y)
  assign full  = {1'b0, x} + {1'b0, (sub ? ~y : y)} + {{DATA_WIDTH{1'b0}}, sub};
  assign sum   = full[DATA_WIDTH-1:0];
  assign carry = full[DATA_WIDTH];

endmodule
